@@ hdl/riff_chunk_tag_finder_core_assert.svh @@
// Assertion macros for the RIFF chunk tag finder.
// Included by the top level; defines nothing else and needs no package.
`ifndef RIFF_CHUNK_TAG_FINDER_CORE_ASSERT_SVH
`define RIFF_CHUNK_TAG_FINDER_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define RCTF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rctf assertion failed");
// Next-cycle implication, checked outside reset.
`define RCTF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rctf assertion failed");
`else
`define RCTF_ASSERT_IMP(label, ante, cons)
`define RCTF_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ hdl/rctf_pkg.sv @@
// Types and constants of the RIFF chunk tag finder.
// No dependencies; imported by riff_chunk_tag_finder_core.
package rctf_pkg;

  typedef enum logic [2:0] {
    PH_CHECK,
    PH_HEADER,
    PH_FORM,
    PH_SKIP,
    PH_EMIT,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_VALUE      = 2'd0,
    KIND_NOT_FOUND  = 2'd1,
    KIND_BAD_HEADER = 2'd2,
    KIND_TRUNCATED  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } result_t;

  // Fourcc codes, first character in the low byte.
  localparam logic [31:0] CC_RIFF = 32'h4646_4952;
  localparam logic [31:0] CC_RIFX = 32'h5846_4952;
  localparam logic [31:0] CC_LIST = 32'h5453_494C;

  localparam int unsigned CFG_ADDR_W = 3;
  // Register index, taken from the word address bit.
  localparam logic REG_WANTED_TAG = 1'b0;

  localparam logic [3:0] HDR_FOURCC_BYTES = 4'd4;
  localparam logic [3:0] HDR_BYTES        = 4'd8;
  localparam logic [32:0] FORM_TYPE_BYTES = 33'd4;

endpackage

@@ hdl/riff_chunk_tag_finder_core.sv @@
// RIFF chunk tag finder: walks a RIFF byte stream and emits the data of the
// first chunk whose fourcc equals wanted_tag. Depends on rctf_pkg and on the
// assertion macros in riff_chunk_tag_finder_core_assert.svh.
//
// One stream byte is taken per clock cycle while the skid entry is empty;
// each byte is settled by one state update (header byte capture, fourcc
// compares and a 33-bit skip down counter), and any result it causes is
// registered in the output register, or in the one-entry skid stage behind
// it while it is held, so a byte is still accepted while one result waits
// to be taken. A RIFF or LIST header descends into its contents, other chunks
// are skipped (with their pad byte), and the matched chunk yields at most
// MAX_VALUE_BYTES data bytes, the last one flagged by tlast. The tuser kind
// on the master side reports not found, a bad opening fourcc or a value cut
// short by the end of the stream. The tag register must only be written while
// the block is idle.
`include "riff_chunk_tag_finder_core_assert.svh"

module riff_chunk_tag_finder_core #(
  parameter int unsigned MAX_VALUE_BYTES = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
  input  logic                             s_axis_tuser,  // [0] stream_start
  input  logic                             s_axis_tlast,  // stream_end
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [7:0] value_byte
  output logic [1:0]                       m_axis_tuser,  // [1:0] kind
  output logic                             m_axis_tlast,  // last_of_value
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rctf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import rctf_pkg::*;

  localparam int unsigned EW = $clog2(MAX_VALUE_BYTES + 1);
  localparam logic [31:0] CAP = 32'(MAX_VALUE_BYTES);

  // Registers.
  logic [31:0]   wanted_tag;
  phase_t        phase;
  logic [63:0]   header_shift;
  logic [3:0]    header_byte_count;
  logic [32:0]   bytes_remaining;
  logic [EW-1:0] emit_remaining;
  result_t       out_res;
  result_t       skid_res;
  logic          out_valid;
  logic          skid_valid;

  // Next values.
  phase_t        phase_walk;
  phase_t        phase_next;
  logic [63:0]   header_shift_next;
  logic [3:0]    header_byte_count_next;
  logic [32:0]   bytes_remaining_next;
  logic [EW-1:0] emit_remaining_next;

  // Current state as seen by this byte (a stream start restarts the walk).
  phase_t        ph_cur;
  logic [63:0]   hs_cur;
  logic [3:0]    cnt_cur;
  logic [32:0]   br_cur;
  logic [EW-1:0] er_cur;

  logic          s_fire;
  logic          cfg_write;
  logic [63:0]   hdr_now;
  logic [3:0]    cnt_inc;
  logic [31:0]   cc;
  logic [31:0]   size;
  logic          hdr_done;
  logic          bad_open;
  logic          descend;
  logic          is_match;
  logic [EW-1:0] emit_init;
  logic [32:0]   skip_len;
  logic [32:0]   br_dec;
  logic [EW-1:0] er_dec;
  result_t       res;
  logic          res_valid;
  logic          out_free;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WANTED_TAG) begin
      prdata = wanted_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_tag <= '0;
    end else if (cfg_write && paddr[2] == REG_WANTED_TAG) begin
      wanted_tag <= pwdata;
    end
  end

  always_comb begin
    ph_cur  = s_axis_tuser ? PH_CHECK : phase;
    hs_cur  = s_axis_tuser ? '0 : header_shift;
    cnt_cur = s_axis_tuser ? '0 : header_byte_count;
    br_cur  = s_axis_tuser ? '0 : bytes_remaining;
    er_cur  = s_axis_tuser ? '0 : emit_remaining;
  end

  // Header byte capture: the incoming byte lands in its slot.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hdr_now[8*i +: 8] = (cnt_cur[2:0] == 3'(i)) ? s_axis_tdata : hs_cur[8*i +: 8];
    end
  end

  assign cnt_inc   = cnt_cur + 4'd1;
  assign cc        = hdr_now[31:0];
  assign size      = hdr_now[63:32];
  assign hdr_done  = cnt_inc >= HDR_BYTES;
  assign bad_open  = (ph_cur == PH_CHECK) && (cnt_inc == HDR_FOURCC_BYTES)
                     && (cc != CC_RIFF) && (cc != CC_RIFX);
  assign descend   = (ph_cur == PH_CHECK) || (cc == CC_RIFF) || (cc == CC_LIST);
  assign is_match  = cc == wanted_tag;
  assign emit_init = (size < CAP) ? size[EW-1:0] : CAP[EW-1:0];
  // Odd sizes carry one pad byte.
  assign skip_len  = {1'b0, size} + {32'd0, size[0]};
  assign br_dec    = (br_cur != '0) ? br_cur - 33'd1 : br_cur;
  assign er_dec    = (er_cur != '0) ? er_cur - EW'(1) : er_cur;

  // Next state.
  always_comb begin
    phase_walk             = ph_cur;
    header_shift_next      = hs_cur;
    header_byte_count_next = cnt_cur;
    bytes_remaining_next   = br_cur;
    emit_remaining_next    = er_cur;
    unique case (ph_cur)
      PH_CHECK, PH_HEADER: begin
        header_shift_next      = hdr_now;
        header_byte_count_next = cnt_inc;
        if (bad_open) begin
          phase_walk = PH_DONE;
        end else if (hdr_done) begin
          if (descend) begin
            phase_walk           = PH_FORM;
            bytes_remaining_next = FORM_TYPE_BYTES;
          end else if (is_match) begin
            emit_remaining_next = emit_init;
            phase_walk          = (emit_init == '0) ? PH_DONE : PH_EMIT;
          end else begin
            bytes_remaining_next = skip_len;
            if (skip_len == '0) begin
              phase_walk             = PH_HEADER;
              header_shift_next      = '0;
              header_byte_count_next = '0;
            end else begin
              phase_walk = PH_SKIP;
            end
          end
        end
      end
      PH_FORM, PH_SKIP: begin
        bytes_remaining_next = br_dec;
        if (br_dec == '0) begin
          phase_walk             = PH_HEADER;
          header_shift_next      = '0;
          header_byte_count_next = '0;
        end
      end
      PH_EMIT: begin
        emit_remaining_next = er_dec;
        if (er_dec == '0) begin
          phase_walk = PH_DONE;
        end
      end
      default: begin
        phase_walk = PH_DONE;
      end
    endcase
    phase_next = (s_axis_tlast && phase_walk != PH_DONE) ? PH_DONE : phase_walk;
  end

  // Result of this byte.
  always_comb begin
    res_valid  = 1'b0;
    res.kind   = KIND_VALUE;
    res.value  = '0;
    res.last   = 1'b0;
    unique case (ph_cur)
      PH_CHECK: begin
        if (bad_open) begin
          res_valid = 1'b1;
          res.kind  = KIND_BAD_HEADER;
        end
      end
      PH_EMIT: begin
        res_valid = 1'b1;
        res.value = s_axis_tdata;
        res.last  = er_dec == '0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    // End of stream before the walk finished replaces any value byte.
    if (s_axis_tlast && phase_walk != PH_DONE) begin
      res_valid = 1'b1;
      res.value = '0;
      res.last  = 1'b0;
      if (phase_walk == PH_EMIT) begin
        res.kind = KIND_TRUNCATED;
      end else if (phase_walk == PH_CHECK && header_byte_count_next < HDR_FOURCC_BYTES) begin
        res.kind = KIND_BAD_HEADER;
      end else begin
        res.kind = KIND_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_CHECK;
      header_shift      <= '0;
      header_byte_count <= '0;
      bytes_remaining   <= '0;
      emit_remaining    <= '0;
    end else if (s_fire) begin
      phase             <= phase_next;
      header_shift      <= header_shift_next;
      header_byte_count <= header_byte_count_next;
      bytes_remaining   <= bytes_remaining_next;
      emit_remaining    <= emit_remaining_next;
    end
  end

  // Output register with a skid entry behind it. The skid entry fills only
  // while the output register holds a transaction that is not taken.
  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || (s_fire && res_valid);
      skid_valid <= 1'b0;
    end else if (s_fire && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (s_fire && res_valid) begin
      skid_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.value;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.last;

  `RCTF_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid)
  `RCTF_ASSERT_IMP(a_emit_nonzero, phase == PH_EMIT, emit_remaining != '0)
  `RCTF_ASSERT_IMP(a_skip_nonzero, phase == PH_FORM || phase == PH_SKIP,
                   bytes_remaining != '0)
  `RCTF_ASSERT_NXT(a_result_registered, s_fire && res_valid && out_free,
                   out_valid && out_res == $past(res))

endmodule
